// ===== hdl/mdcfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcfq_pkg
// types and constants shared by the motor drive command framer queue
// ---------------------------------------------------------------------------
package mdcfq_pkg;

	// request types
	localparam logic [1:0] REQ_SEND     = 2'd0;
	localparam logic [1:0] REQ_RESPONSE = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT  = 2'd2;

	// command kinds
	localparam logic [1:0] KIND_MODE  = 2'd0;
	localparam logic [1:0] KIND_SPEED = 2'd1;
	localparam logic [1:0] KIND_DIR   = 2'd2;

	// command codes placed in the frame
	localparam logic [7:0] CODE_MODE  = 8'h02;
	localparam logic [7:0] CODE_SPEED = 8'h05;
	localparam logic [7:0] CODE_DIR   = 8'h0C;

	// fixed frame bytes
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] CRC_BYTE  = 8'h00;
	localparam logic [7:0] END_BYTE  = 8'hFE;

	// byte positions within a frame
	localparam logic [3:0] POS_SYNC0 = 4'd0;
	localparam logic [3:0] POS_SYNC1 = 4'd1;
	localparam logic [3:0] POS_ADDR  = 4'd2;
	localparam logic [3:0] POS_CODE  = 4'd3;
	localparam logic [3:0] POS_VAL3  = 4'd4;
	localparam logic [3:0] POS_VAL2  = 4'd5;
	localparam logic [3:0] POS_VAL1  = 4'd6;
	localparam logic [3:0] POS_VAL0  = 4'd7;
	localparam logic [3:0] POS_CRC   = 4'd8;
	localparam logic [3:0] POS_END   = 4'd9;

	// configuration register indexes
	localparam logic CFG_NODE_ADDR   = 1'b0;
	localparam logic CFG_SPEED_LIMIT = 1'b1;

	localparam int CFG_W = 15;

	localparam logic [7:0]  ADDR_RESET  = 8'd0;
	localparam logic [14:0] LIMIT_RESET = 15'd25000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  cmd_kind;
		logic [31:0] cmd_value;
	} in_item_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] tx_byte;
		logic       last_of_run;
		logic       op_status;
		logic       busy_now;
	} out_item_t;

	// one queued frame: code byte and value
	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] value;
	} entry_t;

	// work handed to the serializer
	typedef struct packed {
		logic        is_frame;
		logic [7:0]  code;
		logic [31:0] value;
		logic        op_status;
		logic        busy_now;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/mdcfq_queue_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcfq_queue_mem
// frame queue storage, one write and one registered read port
// ---------------------------------------------------------------------------
module mdcfq_queue_mem #(
	parameter int DEPTH = 8,
	parameter int PTR_W = 3
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [PTR_W-1:0]   wr_addr,
	input  wire mdcfq_pkg::entry_t  wr_data,
	input  wire logic               rd_en,
	input  wire logic [PTR_W-1:0]   rd_addr,
	output mdcfq_pkg::entry_t       rd_data
);
	import mdcfq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== hdl/mdcfq_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcfq_framer
// output register and byte serializer for frames and single status items
// ---------------------------------------------------------------------------
module mdcfq_framer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire mdcfq_pkg::job_t  job,
	input  wire logic [7:0]       node_addr,
	output logic                  job_ready,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output mdcfq_pkg::out_item_t  out_item
);
	import mdcfq_pkg::*;

	job_t       job_q;
	logic [7:0] addr_q;
	logic [3:0] pos_q;
	logic       valid_q;
	logic       last;
	logic [7:0] frame_byte;

	assign job_ready = !valid_q;
	assign last      = !job_q.is_frame || (pos_q == POS_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= POS_SYNC0;
		end else if (!valid_q) begin
			if (job_valid) begin
				valid_q <= 1'b1;
				pos_q   <= POS_SYNC0;
			end
		end else if (!out_stall) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// payload, loaded with each new job
	always_ff @(posedge clk) begin
		if (!valid_q && job_valid) begin
			job_q  <= job;
			addr_q <= node_addr;
		end
	end

	always_comb begin
		case (pos_q)
			POS_SYNC0: frame_byte = SYNC_BYTE;
			POS_SYNC1: frame_byte = SYNC_BYTE;
			POS_ADDR:  frame_byte = addr_q;
			POS_CODE:  frame_byte = job_q.code;
			POS_VAL3:  frame_byte = job_q.value[31:24];
			POS_VAL2:  frame_byte = job_q.value[23:16];
			POS_VAL1:  frame_byte = job_q.value[15:8];
			POS_VAL0:  frame_byte = job_q.value[7:0];
			POS_CRC:   frame_byte = CRC_BYTE;
			POS_END:   frame_byte = END_BYTE;
			default:   frame_byte = CRC_BYTE;
		endcase
	end

	assign out_valid            = valid_q;
	assign out_item.has_byte    = job_q.is_frame;
	assign out_item.tx_byte     = job_q.is_frame ? frame_byte : 8'h00;
	assign out_item.last_of_run = last;
	assign out_item.op_status   = job_q.op_status;
	assign out_item.busy_now    = job_q.busy_now;

endmodule
`default_nettype wire

// ===== hdl/motor_drive_command_framer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// motor_drive_command_framer_queue
// builds 10-byte motor drive command frames, queues them while the line is
// busy and sends the oldest one on a response or timeout event
// ---------------------------------------------------------------------------
//
//  channel  signals                          direction  meaning
//  in       in_valid, in_stall, in_item      to block   requests and events
//  out      out_valid, out_stall, out_item   from block frame bytes and status
//  cfg      cfg_we, cfg_index, cfg_data      to block   address and speed limit
//
// one item at a time: an item that sends a frame gives ten output items, one
// per cycle while the output is not stalled, from the serializer output
// register, and the next item is taken the cycle after the last byte leaves;
// a frame taken from the queue first passes through the registered memory read.
// reset clears the line state and queue pointers; the queue memory is not
// cleared since entries are only read after being written.
// a stall on the output holds the current byte and the input stays stalled.
//
module motor_drive_command_framer_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire mdcfq_pkg::in_item_t         in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output mdcfq_pkg::out_item_t             out_item,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [mdcfq_pkg::CFG_W-1:0] cfg_data
);
	import mdcfq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// sequencer states
	localparam logic ST_IDLE = 1'b0;   // ready for an item
	localparam logic ST_READ = 1'b1;   // queue read in flight

	logic             state_q;
	logic             line_busy_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       node_addr_q;
	logic [14:0]      speed_limit_q;

	logic   accept;
	logic   job_valid;
	logic   job_ready;
	job_t   job;
	logic   push;
	logic   pop;
	logic   set_busy;
	logic   clr_busy;
	logic   queue_full;
	logic   kind_ok;
	logic [7:0]  code;
	logic [31:0] value;
	entry_t wr_entry;
	entry_t rd_entry;

	// input is taken only when the sequencer and the serializer are both free
	assign in_stall   = (state_q != ST_IDLE) || !job_ready;
	assign accept     = in_valid && !in_stall;
	assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));

	// command code lookup and speed clamp
	always_comb begin
		kind_ok = 1'b1;
		value   = in_item.cmd_value;
		case (in_item.cmd_kind)
			KIND_MODE:  code = CODE_MODE;
			KIND_SPEED: begin
				code = CODE_SPEED;
				if (in_item.cmd_value > {17'd0, speed_limit_q}) begin
					value = {17'd0, speed_limit_q};
				end
			end
			KIND_DIR:   code = CODE_DIR;
			default: begin
				code    = CRC_BYTE;
				kind_ok = 1'b0;
			end
		endcase
	end

	assign wr_entry.code  = code;
	assign wr_entry.value = value;

	// request decode: what goes to the serializer and how the queue moves
	always_comb begin
		job_valid     = 1'b0;
		job.is_frame  = 1'b0;
		job.code      = code;
		job.value     = value;
		job.op_status = 1'b0;
		job.busy_now  = line_busy_q;
		push          = 1'b0;
		pop           = 1'b0;
		set_busy      = 1'b0;
		clr_busy      = 1'b0;
		if (state_q == ST_READ) begin
			// queued frame arrives from memory
			job_valid    = 1'b1;
			job.is_frame = 1'b1;
			job.code     = rd_entry.code;
			job.value    = rd_entry.value;
			job.busy_now = 1'b1;
		end else if (accept) begin
			case (in_item.req_type)
				REQ_SEND: begin
					job_valid = 1'b1;
					if (!kind_ok) begin
						job.op_status = 1'b1;
					end else if (!line_busy_q) begin
						job.is_frame = 1'b1;
						job.busy_now = 1'b1;
						set_busy     = 1'b1;
					end else if (queue_full) begin
						job.op_status = 1'b1;
					end else begin
						push = 1'b1;
					end
				end
				REQ_RESPONSE, REQ_TIMEOUT: begin
					if (count_q == '0) begin
						job_valid    = 1'b1;
						job.busy_now = 1'b0;
						clr_busy     = 1'b1;
					end else begin
						// frame goes out once the read data is back
						pop = 1'b1;
					end
				end
				default: begin
					job_valid = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			line_busy_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (pop) state_q <= ST_READ;
				ST_READ: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (set_busy) begin
				line_busy_q <= 1'b1;
			end else if (clr_busy) begin
				line_busy_q <= 1'b0;
			end
			if (push) begin
				tail_q  <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (pop) begin
				head_q  <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q   <= ADDR_RESET;
			speed_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_ADDR:   node_addr_q   <= cfg_data[7:0];
				CFG_SPEED_LIMIT: speed_limit_q <= cfg_data[14:0];
				default:         speed_limit_q <= speed_limit_q;
			endcase
		end
	end

	mdcfq_queue_mem #(
		.DEPTH(QUEUE_DEPTH),
		.PTR_W(PTR_W)
	) u_queue_mem (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(tail_q),
		.wr_data(wr_entry),
		.rd_en  (pop),
		.rd_addr(head_q),
		.rd_data(rd_entry)
	);

	mdcfq_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.node_addr(node_addr_q),
		.job_ready(job_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

`ifndef SYNTHESIS
	// queue occupancy never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// frames wait in the queue only while the line is busy
	a_queue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> line_busy_q)
		else $error("queued frames with idle line");

	// serializer must be free when the queued frame comes back from memory
	a_read_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> job_ready)
		else $error("queue read returned while serializer busy");

	// a dequeue always lands in the read state next cycle
	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_READ))
		else $error("dequeue without read state");
`endif

endmodule
`default_nettype wire

// ===== bench/motor_drive_command_framer_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_drive_command_framer_queue_tb
// self-checking bench for the command framer queue: a shadow of the line and
// frame queue predicts every output item, random idling on both channels,
// directed corner items first, then random phases under changing settings
// ---------------------------------------------------------------------------
module motor_drive_command_framer_queue_tb;
	import mdcfq_pkg::*;

	localparam int FRAME_SLOTS   = 8;
	localparam int FRAME_BYTES   = 10;
	localparam int SETTLE_CYCLES = 14;     // a little over the length of one frame
	localparam int IDLE_LIMIT    = 2000;   // well above the longest receiver hold-off
	localparam int LONG_HOLD     = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 26;

	// codes the block does not know, kept apart from the package ones
	localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	// line state and queued frames as the block should hold them, plus the
	// output items still owed by it
	class framer_shadow;
		logic [7:0]  dev_addr;
		logic [14:0] speed_cap;
		bit          line_busy;
		entry_t      parked[$];
		out_item_t   pending_bytes[$];
		int          flaws;

		function new();
			dev_addr  = ADDR_RESET;
			speed_cap = LIMIT_RESET;
			line_busy = 1'b0;
			flaws     = 0;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == CFG_NODE_ADDR)
				dev_addr = data[7:0];
			else
				speed_cap = data[14:0];
		endfunction

		function void push_status(logic failed, logic busy);
			pending_bytes.push_back(out_item_t'{has_byte: 1'b0, tx_byte: 8'h00,
				last_of_run: 1'b1, op_status: failed, busy_now: busy});
		endfunction

		// address comes from the register at send time, not at queue time
		function void push_frame(entry_t e);
			logic [7:0] frame [FRAME_BYTES];
			frame[0] = SYNC_BYTE;
			frame[1] = SYNC_BYTE;
			frame[2] = dev_addr;
			frame[3] = e.code;
			frame[4] = e.value[31:24];
			frame[5] = e.value[23:16];
			frame[6] = e.value[15:8];
			frame[7] = e.value[7:0];
			frame[8] = CRC_BYTE;
			frame[9] = END_BYTE;
			line_busy = 1'b1;
			for (int i = 0; i < FRAME_BYTES; i++)
				pending_bytes.push_back(out_item_t'{has_byte: 1'b1, tx_byte: frame[i],
					last_of_run: (i == FRAME_BYTES - 1), op_status: 1'b0, busy_now: 1'b1});
		endfunction

		function void take_request(in_item_t it);
			entry_t e;
			e.value = it.cmd_value;
			case (it.req_type)
				REQ_SEND: begin
					case (it.cmd_kind)
						KIND_MODE: e.code = CODE_MODE;
						KIND_SPEED: begin
							e.code = CODE_SPEED;
							if (e.value > speed_cap)
								e.value = speed_cap;
						end
						KIND_DIR: e.code = CODE_DIR;
						default: begin
							push_status(1'b1, line_busy);
							return;
						end
					endcase
					if (!line_busy)
						push_frame(e);
					else if (parked.size() >= FRAME_SLOTS)
						push_status(1'b1, 1'b1);
					else begin
						parked.push_back(e);
						push_status(1'b0, 1'b1);
					end
				end
				REQ_RESPONSE, REQ_TIMEOUT: begin
					if (parked.size() == 0) begin
						line_busy = 1'b0;
						push_status(1'b0, 1'b0);
					end else
						push_frame(parked.pop_front());
				end
				default: push_status(1'b0, line_busy);
			endcase
		endfunction

		function void check_byte(out_item_t got);
			out_item_t want;
			if (pending_bytes.size() == 0) begin
				$error("output item with nothing pending: %p", got);
				flaws++;
				return;
			end
			want = pending_bytes.pop_front();
			if (got.has_byte !== want.has_byte) begin
				$error("has_byte: expected %0d, got %0d", want.has_byte, got.has_byte);
				flaws++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
				flaws++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", want.last_of_run,
					got.last_of_run);
				flaws++;
			end
			if (got.op_status !== want.op_status) begin
				$error("op_status: expected %0d, got %0d", want.op_status, got.op_status);
				flaws++;
			end
			if (got.busy_now !== want.busy_now) begin
				$error("busy_now: expected %0d, got %0d", want.busy_now, got.busy_now);
				flaws++;
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_NODE_ADDR;
	logic [CFG_W-1:0]     cfg_data  = '0;

	framer_shadow shadow;
	bit tx_gaps   = 1'b1;    // sender idles between items
	bit rx_gaps   = 1'b1;    // receiver stalls at random
	int hold_req  = 0;       // one long receiver hold-off, in cycles

	wire in_take  = in_valid && !in_stall;
	wire out_take = out_valid && !out_stall;

	motor_drive_command_framer_queue #(
		.QUEUE_DEPTH(FRAME_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly no idling, often a short gap, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic in_item_t request(logic [1:0] req, logic [1:0] kind,
		logic [31:0] value);
		in_item_t it;
		it.req_type  = req;
		it.cmd_kind  = kind;
		it.cmd_value = value;
		return it;
	endfunction

	// well-formed sends and events dominate; unknown codes are the noise
	function automatic in_item_t random_request(int send_pct);
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < send_pct) begin
			it.req_type = REQ_SEND;
			it.cmd_kind = ($urandom_range(0, 19) == 0) ? KIND_UNKNOWN
				: 2'($urandom_range(0, 2));
		end else begin
			if (r < 96)
				it.req_type = $urandom_range(0, 1) ? REQ_RESPONSE : REQ_TIMEOUT;
			else
				it.req_type = REQ_UNKNOWN;
			it.cmd_kind = 2'($urandom_range(0, 3));
		end
		case ($urandom_range(0, 3))
			0: it.cmd_value = $urandom;
			1: it.cmd_value = $urandom_range(0, 32767);
			2: it.cmd_value = $urandom_range(24990, 30010);   // around the clamp
			default: it.cmd_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		return it;
	endfunction

	// offer one item and hold it until the block takes it
	task automatic send_request(input in_item_t it);
		int gap;
		gap = tx_gaps ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering until every owed output item has come, then let the
	// block settle
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back, only while the block is idle
	task automatic configure(input logic [7:0] addr, input logic [14:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NODE_ADDR;
		cfg_data  <= CFG_W'(addr);
		@(posedge clk);
		cfg_index <= CFG_SPEED_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// receiver: random stalls, plus the long hold-off when asked for
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_gaps) begin
				n = idle_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// handshake monitor: outputs are checked before the same edge's input is
	// noted, since an item's results never leave in the cycle it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_take)
				shadow.check_byte(out_item);
			if (cfg_we)
				shadow.write_reg(cfg_index, cfg_data);
			if (in_take)
				shadow.take_request(in_item);
		end
	end

	// watchdog: ends the run after too many cycles with no handshake at all
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || in_take || out_take || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("motor_drive_command_framer_queue verification failed");
		$finish;
	end

	initial begin
		logic [7:0]  addr;
		logic [14:0] limit;
		int          send_pct;
		shadow = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// events and unknown codes on an idle line
		send_request(request(REQ_RESPONSE, KIND_MODE, 32'h0));
		send_request(request(REQ_TIMEOUT, KIND_DIR, 32'hFFFF_FFFF));
		send_request(request(REQ_UNKNOWN, KIND_SPEED, 32'h1234_5678));
		send_request(request(REQ_SEND, KIND_UNKNOWN, 32'hFFFF_FFFF));
		// first frame goes straight out, then unknowns while busy
		send_request(request(REQ_SEND, KIND_MODE, 32'h0));
		send_request(request(REQ_SEND, KIND_UNKNOWN, 32'h0));
		send_request(request(REQ_UNKNOWN, KIND_UNKNOWN, 32'hFFFF_FFFF));
		// fill all eight slots, speed values on both sides of the clamp
		send_request(request(REQ_SEND, KIND_SPEED, 32'hFFFF_FFFF));
		send_request(request(REQ_SEND, KIND_SPEED, 32'd25000));
		send_request(request(REQ_SEND, KIND_SPEED, 32'd25001));
		send_request(request(REQ_SEND, KIND_SPEED, 32'h0));
		send_request(request(REQ_SEND, KIND_DIR, 32'hA5A5_5A5A));
		send_request(request(REQ_SEND, KIND_MODE, 32'hFFFF_FFFF));
		send_request(request(REQ_SEND, KIND_DIR, 32'h0));
		send_request(request(REQ_SEND, KIND_MODE, 32'h5A5A_A5A5));
		// queue full: refused
		send_request(request(REQ_SEND, KIND_SPEED, 32'h1));
		// new address while frames wait: queued frames pick it up when sent
		drain_and_settle();
		configure(8'hFF, 15'd30000);
		send_request(request(REQ_RESPONSE, KIND_MODE, 32'h0));
		send_request(request(REQ_TIMEOUT, KIND_MODE, 32'h0));
		send_request(request(REQ_SEND, KIND_SPEED, 32'd30000));

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			drain_and_settle();
			addr  = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
			limit = (p == 0) ? 15'd0 : (p == 1) ? 15'd30000 : (p == 2) ? LIMIT_RESET
				: 15'($urandom_range(0, 30000));
			configure(addr, limit);
			send_pct = (p % 2 == 0) ? 70 : 40;
			// one phase with no idling at all
			tx_gaps = (p != 3);
			rx_gaps = (p != 3);
			// long receiver hold-off while the sender keeps offering
			if (p == 5) begin
				tx_gaps  = 1'b0;
				send_pct = 75;
				hold_req = LONG_HOLD;
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_request(random_request(send_pct));
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.flaws == 0 && shadow.pending_bytes.size() == 0)
			$display("motor_drive_command_framer_queue verification clean");
		else
			$display("motor_drive_command_framer_queue verification failed");
		$finish;
	end

endmodule
